@@ src/scd_pkg.sv @@
package scd_pkg;

    // Payload phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_VOLUME = 2'd1;
    localparam logic [1:0] PH_COLOUR = 2'd2;

    // Event codes on the result channel
    localparam logic [1:0] EV_MODE   = 2'd0;
    localparam logic [1:0] EV_VOLUME = 2'd1;
    localparam logic [1:0] EV_COLOUR = 2'd2;

    // Command and digit characters
    localparam logic [7:0] CH_JOYSTICK = 8'h6A; // 'j'
    localparam logic [7:0] CH_DPAD     = 8'h64; // 'd'
    localparam logic [7:0] CH_VOLUME   = 8'h56; // 'V'
    localparam logic [7:0] CH_COLOUR   = 8'h23; // '#'
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LA       = 8'h61;
    localparam logic [7:0] CH_LF       = 8'h66;
    localparam logic [7:0] CH_UA       = 8'h41;
    localparam logic [7:0] CH_UF       = 8'h46;

    localparam logic [7:0] DUTY_INVERT = 8'hFF;

    localparam logic [2:0] VOLUME_DIGITS = 3'd3;
    localparam logic [2:0] RED_END       = 3'd2;
    localparam logic [2:0] GREEN_END     = 3'd4;
    localparam logic [2:0] BLUE_END      = 3'd6;

    localparam logic [9:0] VOLUME_MAX = 10'd999;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] digit_index;
        logic       field_ended;
        logic [9:0] number_acc;
        logic       mode;
        logic [9:0] volume;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Decimal digit, or hex digit in either case when hex is set
    function automatic digit_t digit_decode(logic [7:0] c, logic hex);
        digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_ZERO);
        end else if (hex && c >= CH_LA && c <= CH_LF) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_LA) + 4'd10;
        end else if (hex && c >= CH_UA && c <= CH_UF) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_UA) + 4'd10;
        end
        return d;
    endfunction

endpackage

@@ src/serial_command_decoder.sv @@
// Channel  Direction  Handshake        Payload
// s_       in         s_valid/s_ready  s_rx_byte (8 bit received byte)
// m_       out        m_valid/m_ready  m_event_kind, m_joystick_mode, m_volume_level,
//                                      m_red_duty, m_green_duty, m_blue_duty
//
// One byte per cycle sustained while no result is held. A byte is held in the input
// register, then the decode step updates the state and, where the byte completes a
// command, loads the result register, so each result passes both registers.
// aresetn (synchronous, active low) returns to idle, d-pad mode, all values zero.
// A held result stalls the decode step only; the input register still takes
// a byte while it is empty, and frees in the same cycle the result is taken.
module serial_command_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_kind,
    output logic       m_joystick_mode,
    output logic [9:0] m_volume_level,
    output logic [7:0] m_red_duty,
    output logic [7:0] m_green_duty,
    output logic [7:0] m_blue_duty
);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] rx_byte_reg;

    // Decoder state; also the payload of the result, since it cannot move
    // while a result is held
    scd_pkg::state_t state_reg;
    scd_pkg::state_t state_next;
    scd_pkg::state_t step_state;

    // Result register
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [1:0] kind_reg;

    logic       step_emit;
    logic [1:0] step_kind;
    logic       step_en;

    // Decode step runs when a byte waits and the result slot is free
    assign step_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    scd_step u_step (
        .state_cur  (state_reg),
        .rx_byte    (rx_byte_reg),
        .state_next (step_state),
        .emit       (step_emit),
        .event_kind (step_kind)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    assign state_next = step_en ? step_state : state_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en) begin
            m_valid_next = step_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            state_reg    <= state_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rx_byte_reg <= s_rx_byte;
        end
        if (step_en && step_emit) begin
            kind_reg <= step_kind;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = kind_reg;
    assign m_joystick_mode = state_reg.mode;
    assign m_volume_level  = state_reg.volume;
    assign m_red_duty      = state_reg.red;
    assign m_green_duty    = state_reg.green;
    assign m_blue_duty     = state_reg.blue;

`ifndef SYNTHESIS
    // Idle never carries a partial payload count
    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == scd_pkg::PH_IDLE |-> state_reg.digit_index == 3'd0)
        else $error("digit index not cleared in idle");

    // Volume payload is at most three bytes
    a_volume_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == scd_pkg::PH_VOLUME |-> state_reg.digit_index < 3'd3)
        else $error("volume payload overran");

    // Three decimal digits cannot exceed 999
    a_volume_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_volume_level <= scd_pkg::VOLUME_MAX)
        else $error("volume out of range");

    // Every result returns the decoder to idle
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && step_emit |=> state_reg.phase == scd_pkg::PH_IDLE)
        else $error("result left decoder mid-command");

    // State holds while a result is stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(state_reg))
        else $error("state moved under a held result");
`endif

endmodule

@@ src/scd_step.sv @@
module scd_step (
    input  scd_pkg::state_t state_cur,
    input  logic [7:0]      rx_byte,
    output scd_pkg::state_t state_next,
    output logic            emit,
    output logic [1:0]      event_kind
);

    scd_pkg::digit_t dig;
    logic            hex;
    logic [9:0]      acc_scaled;
    logic [9:0]      acc_upd;
    logic            ended_upd;
    logic [2:0]      idx_inc;

    assign hex = (state_cur.phase == scd_pkg::PH_COLOUR);
    assign dig = scd_pkg::digit_decode(rx_byte, hex);

    // x10 as x8 + x2, x16 as a shift; both wrap at 10 bits
    always_comb begin
        if (hex) begin
            acc_scaled = {state_cur.number_acc[5:0], 4'b0000};
        end else begin
            acc_scaled = {state_cur.number_acc[6:0], 3'b000}
                       + {state_cur.number_acc[8:0], 1'b0};
        end
    end

    assign ended_upd = state_cur.field_ended | ~dig.valid;
    assign acc_upd   = ended_upd ? state_cur.number_acc
                                 : acc_scaled + {6'd0, dig.value};
    assign idx_inc   = state_cur.digit_index + 3'd1;

    always_comb begin
        state_next = state_cur;
        emit       = 1'b0;
        event_kind = scd_pkg::EV_MODE;
        unique case (state_cur.phase)
            scd_pkg::PH_VOLUME: begin
                state_next.field_ended = ended_upd;
                state_next.number_acc  = acc_upd;
                state_next.digit_index = idx_inc;
                if (idx_inc >= scd_pkg::VOLUME_DIGITS) begin
                    state_next.volume      = acc_upd;
                    state_next.phase       = scd_pkg::PH_IDLE;
                    state_next.digit_index = 3'd0;
                    state_next.number_acc  = 10'd0;
                    state_next.field_ended = 1'b0;
                    emit                   = 1'b1;
                    event_kind             = scd_pkg::EV_VOLUME;
                end
            end
            scd_pkg::PH_COLOUR: begin
                state_next.field_ended = ended_upd;
                state_next.number_acc  = acc_upd;
                state_next.digit_index = idx_inc;
                if (idx_inc == scd_pkg::RED_END) begin
                    state_next.red         = acc_upd[7:0] ^ scd_pkg::DUTY_INVERT;
                    state_next.number_acc  = 10'd0;
                    state_next.field_ended = 1'b0;
                end else if (idx_inc == scd_pkg::GREEN_END) begin
                    state_next.green       = acc_upd[7:0] ^ scd_pkg::DUTY_INVERT;
                    state_next.number_acc  = 10'd0;
                    state_next.field_ended = 1'b0;
                end else if (idx_inc >= scd_pkg::BLUE_END) begin
                    state_next.blue        = acc_upd[7:0] ^ scd_pkg::DUTY_INVERT;
                    state_next.number_acc  = 10'd0;
                    state_next.field_ended = 1'b0;
                    state_next.phase       = scd_pkg::PH_IDLE;
                    state_next.digit_index = 3'd0;
                    emit                   = 1'b1;
                    event_kind             = scd_pkg::EV_COLOUR;
                end
            end
            default: begin
                // idle, and the spare phase code
                state_next.phase       = scd_pkg::PH_IDLE;
                state_next.digit_index = 3'd0;
                unique case (rx_byte)
                    scd_pkg::CH_JOYSTICK: begin
                        state_next.mode = 1'b1;
                        emit            = 1'b1;
                    end
                    scd_pkg::CH_DPAD: begin
                        state_next.mode = 1'b0;
                        emit            = 1'b1;
                    end
                    scd_pkg::CH_VOLUME: begin
                        state_next.phase       = scd_pkg::PH_VOLUME;
                        state_next.number_acc  = 10'd0;
                        state_next.field_ended = 1'b0;
                    end
                    scd_pkg::CH_COLOUR: begin
                        state_next.phase       = scd_pkg::PH_COLOUR;
                        state_next.number_acc  = 10'd0;
                        state_next.field_ended = 1'b0;
                    end
                    default: begin
                        // other bytes dropped
                    end
                endcase
            end
        endcase
    end

endmodule
